// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
// No dependencies; imported by every module of the block.
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 7;
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CFG_W-1:0]         cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // capture sample, read oldest ring slot
        logic cfg_we;   // window size write
        logic remove;   // drop oldest sample from sorted row, write ring
        logic insert;   // insert new sample into sorted row
        logic load_out; // move median into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;     // window already holds k samples
        logic due;      // window holds k samples after insert
        logic out_busy; // output register holds an untaken request
    } status_t;

    // Out-of-range sizes clamp: zero acts as 1, above the maximum as the maximum.
    function automatic cnt_t eff_window(input cfg_t w);
        cnt_t k;
        if (w == '0) begin
            k = cnt_t'(1);
        end else if (int'(w) > WINDOW_MAX) begin
            k = cnt_t'(WINDOW_MAX);
        end else begin
            k = cnt_t'(w);
        end
        return k;
    endfunction

endpackage

// ===== design/swm_ctrl.sv =====
// Controller of the sliding-window median filter: sequences capture, removal,
// insertion, result hand-off and window size writes. Depends on swm_pkg.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cfg_ready  = 1'b1;
                cmd.cfg_we = cfg_valid;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.due) begin
                    state_next = ST_IDLE;
                end else if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/swm_datapath.sv =====
// Datapath of the sliding-window median filter: sample ring memory, row of
// sorting cells, window size register and output register. Depends on swm_pkg.
module swm_datapath
    import swm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    cmd,
    output status_t status,
    input  sample_t s_sample,
    input  cfg_t    cfg_window_size,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_median
);

    sample_t ring_mem [WINDOW_MAX];
    sample_t cells_reg [WINDOW_MAX];
    sample_t cells_next [WINDOW_MAX];

    sample_t sample_reg;
    sample_t old_reg;
    sample_t median_reg;
    sample_t median_sel;
    logic    m_valid_reg;
    cnt_t    count_reg;
    cnt_t    k_reg;
    cnt_t    mid;
    idx_t    ptr_reg;

    assign mid = cnt_t'((k_reg - cnt_t'(1)) >> 1);

    // ring: one read, one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            old_reg <= ring_mem[ptr_reg];
        end
        if (cmd.remove) begin
            ring_mem[ptr_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= cnt_t'(1);
            count_reg <= '0;
            ptr_reg   <= '0;
        end else if (cmd.cfg_we) begin
            k_reg     <= eff_window(cfg_window_size);
            count_reg <= '0;
            ptr_reg   <= '0;
        end else if (cmd.remove) begin
            if (status.full) begin
                count_reg <= count_reg - cnt_t'(1);
            end
            if (cnt_t'(ptr_reg) + cnt_t'(1) == k_reg) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_reg + idx_t'(1);
            end
        end else if (cmd.insert) begin
            count_reg <= count_reg + cnt_t'(1);
        end
    end

    // Sorted row. Duplicates are contiguous, so removing one copy of the old
    // value is a left shift of every valid cell at or above it.
    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            cells_next[i] = cells_reg[i];
            if (cmd.remove && status.full) begin
                if (i < WINDOW_MAX - 1) begin
                    if (cnt_t'(i) < count_reg && cells_reg[i] >= old_reg) begin
                        cells_next[i] = cells_reg[(i < WINDOW_MAX - 1) ? i + 1 : i];
                    end
                end
            end else if (cmd.insert) begin
                if (i > 0 && cnt_t'(i - 1) < count_reg
                        && cells_reg[(i > 0) ? i - 1 : 0] > sample_reg) begin
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                end else if (!(cnt_t'(i) < count_reg) || cells_reg[i] > sample_reg) begin
                    cells_next[i] = sample_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_comb begin
        median_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (cnt_t'(i) == mid) begin
                median_sel = median_sel | cells_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            median_reg <= median_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.full     = (count_reg >= k_reg);
    assign status.due      = (count_reg == k_reg);
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid  = m_valid_reg;
    assign m_median = median_reg;

endmodule

// ===== design/sliding_window_median.sv =====
// Sliding-window median filter, top level: controller plus datapath.
// A sample passes through capture, remove, insert and hand-off in turn; the
// next sample is taken only after hand-off, which waits while the output
// register holds an untaken request. Results appear once the window is full.
// Reset (aresetn, synchronous): window size 1, empty window; ring and
// sorted row contents are not cleared and need no clearing pass.
module sliding_window_median
    import swm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  sample_t s_sample,
    output logic    m_valid,
    input  logic    m_ready,
    output sample_t m_median,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  cfg_t    cfg_window_size
);

    cmd_t    cmd;
    status_t status;

    swm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swm_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_sample        (s_sample),
        .cfg_window_size (cfg_window_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median)
    );

endmodule

// ===== design/swm_checker.sv =====
// Port-level checks for the sliding-window median filter, bound to the
// top level. Depends on swm_pkg.
module swm_checker
    import swm_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input logic    m_valid,
    input logic    m_ready,
    input sample_t m_median
);

    // stalled result request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median))
        else $error("result request dropped or changed while stalled");

    // one sample in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous sample in work");

    // a result never appears in the cycle right after an input was taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
